@@ design/cfb_pkg.sv @@
package cfb_pkg;

    localparam int CMD_W   = 3;
    localparam int COORD_W = 10;
    localparam int SIZE_W  = 9;
    localparam int THICK_W = 5;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [THICK_W-1:0] t_thick;
    typedef logic [PIX_W-1:0]   t_pixel;
    typedef logic [1:0]         t_reg_idx;

    localparam t_cmd CMD_READ  = 3'd0;
    localparam t_cmd CMD_WRITE = 3'd1;
    localparam t_cmd CMD_HLINE = 3'd2;
    localparam t_cmd CMD_VLINE = 3'd3;
    localparam t_cmd CMD_BOX   = 3'd4;
    localparam t_cmd CMD_CLEAR = 3'd5;

    localparam t_reg_idx REG_CANVAS_W = 2'd0;
    localparam t_reg_idx REG_CANVAS_H = 2'd1;
    localparam t_reg_idx REG_THICK    = 2'd2;

    localparam t_size  RST_CANVAS_W = 9'd256;
    localparam t_size  RST_CANVAS_H = 9'd256;
    localparam t_thick RST_THICK    = 5'd1;
    localparam t_thick THICK_MAX    = 5'd16;

endpackage

@@ design/cfb_ram.sv @@
module cfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read data holds while the port is not enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/clipped_framebuffer_fill.sv @@
// A fill passes the clip, base and start states and then makes one RAM write per cycle
// through the shared address adder for each clipped pixel; a full clear writes all W*H, and
// a fill clipped down to nothing returns to idle from the base state.
// A pixel read takes the same path for its one pixel, skipping start and fill if outside
// the canvas, and waits while an earlier result is still stalled in the output register.
// Throughput: one command at a time; the input stalls from accept until the command is done.
// Reset (synchronous, active low) sets canvas 256x256, thickness 1, clears the sequencer and
// the output valid. The pixel RAM is not cleared; unwritten pixels read undefined.
module clipped_framebuffer_fill #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cfb_pkg::PADDR_W-1:0]       paddr,
    input  logic [cfb_pkg::PDATA_W-1:0]       pwdata,
    output logic [cfb_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cfb_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [cfb_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [cfb_pkg::COORD_W-1:0] i_pos_y,
    input  logic [cfb_pkg::SIZE_W-1:0]        i_span_len,
    input  logic [cfb_pkg::SIZE_W-1:0]        i_box_rows,
    input  logic [cfb_pkg::CH_W-1:0]          i_red_in,
    input  logic [cfb_pkg::CH_W-1:0]          i_green_in,
    input  logic [cfb_pkg::CH_W-1:0]          i_blue_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [cfb_pkg::CH_W-1:0]          o_red_out,
    output logic [cfb_pkg::CH_W-1:0]          o_green_out,
    output logic [cfb_pkg::CH_W-1:0]          o_blue_out,
    output logic                              o_out_of_range
);
    import cfb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLIP   = 3'd1;
    localparam logic [2:0] S_BASE   = 3'd2;
    localparam logic [2:0] S_START  = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;

    // configuration
    t_size  r_canvas_w, n_canvas_w;
    t_size  r_canvas_h, n_canvas_h;
    t_thick r_thick,    n_thick;
    t_size  cw, ch, thick_eff;
    logic   cfg_wr;

    // sequencer
    logic [2:0] r_state, n_state;
    logic       r_is_read, n_is_read;
    logic       r_oor, n_oor;
    logic signed [COORD_W-1:0] r_x, n_x, r_y, n_y;
    t_size  r_w, n_w, r_h, n_h;
    t_pixel r_color, n_color;
    t_size  r_x0, n_x0, r_x1, n_x1, r_y0, n_y0, r_y1, n_y1;
    t_size  r_col, n_col, r_row, n_row;
    t_size  r_stride, n_stride;
    logic [2*SIZE_W-1:0] r_prod, n_prod;
    logic [AW-1:0] r_addr, n_addr;

    // output register
    logic   r_out_valid, n_out_valid;
    t_pixel r_out_pix, n_out_pix;
    logic   r_out_oor, n_out_oor;

    // clip arithmetic
    logic signed [COORD_W:0] xe, ye, cw_s, ch_s;
    t_size  x0_c, x1_c, y0_c, y1_c;
    logic   empty;
    logic [SIZE_W:0] span, stride_c;
    logic   row_end, last_row;

    // shared address adder
    logic [AW-1:0] add_a, add_b, add_sum;

    // ram
    logic   ram_en, ram_we;
    t_pixel ram_rdata;
    logic   in_acc, out_free;

    assign cw        = (int'(r_canvas_w) > MAX_WIDTH)  ? SIZE_W'(MAX_WIDTH)  : r_canvas_w;
    assign ch        = (int'(r_canvas_h) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : r_canvas_h;
    assign thick_eff = {4'b0000, ((r_thick > THICK_MAX) ? THICK_MAX : r_thick)};

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            REG_CANVAS_W: prdata = {{(PDATA_W-SIZE_W){1'b0}}, r_canvas_w};
            REG_CANVAS_H: prdata = {{(PDATA_W-SIZE_W){1'b0}}, r_canvas_h};
            REG_THICK:    prdata = {{(PDATA_W-THICK_W){1'b0}}, r_thick};
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        n_canvas_w = r_canvas_w;
        n_canvas_h = r_canvas_h;
        n_thick    = r_thick;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_CANVAS_W: n_canvas_w = pwdata[SIZE_W-1:0];
                REG_CANVAS_H: n_canvas_h = pwdata[SIZE_W-1:0];
                REG_THICK:    n_thick    = pwdata[THICK_W-1:0];
                default:      ;
            endcase
        end
    end

    // clip the rectangle to the canvas; x1/y1 are exclusive
    assign xe   = $signed({r_x[COORD_W-1], r_x}) + $signed({2'b00, r_w});
    assign ye   = $signed({r_y[COORD_W-1], r_y}) + $signed({2'b00, r_h});
    assign cw_s = $signed({2'b00, cw});
    assign ch_s = $signed({2'b00, ch});
    assign x0_c = r_x[COORD_W-1] ? '0 : r_x[SIZE_W-1:0];
    assign y0_c = r_y[COORD_W-1] ? '0 : r_y[SIZE_W-1:0];
    assign x1_c = (xe <= 0) ? '0 : ((xe > cw_s) ? cw : xe[SIZE_W-1:0]);
    assign y1_c = (ye <= 0) ? '0 : ((ye > ch_s) ? ch : ye[SIZE_W-1:0]);

    assign empty    = (r_x1 <= r_x0) || (r_y1 <= r_y0);
    assign span     = {1'b0, r_x1} - {1'b0, r_x0};
    // jump from the last pixel of a row to the first of the next
    assign stride_c = {1'b0, cw} - span + 10'd1;
    assign row_end  = ({1'b0, r_col} + 10'd1) == {1'b0, r_x1};
    assign last_row = ({1'b0, r_row} + 10'd1) == {1'b0, r_y1};

    assign add_a   = (r_state == S_START) ? AW'(r_prod) : r_addr;
    assign add_b   = (r_state == S_START) ? AW'(r_x0) :
                     (row_end ? AW'(r_stride) : AW'(1));
    assign add_sum = add_a + add_b;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign ram_en   = (r_state == S_FILL);
    assign ram_we   = !r_is_read;

    always_comb begin
        n_state     = r_state;
        n_is_read   = r_is_read;
        n_oor       = r_oor;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_h         = r_h;
        n_color     = r_color;
        n_x0        = r_x0;
        n_x1        = r_x1;
        n_y0        = r_y0;
        n_y1        = r_y1;
        n_col       = r_col;
        n_row       = r_row;
        n_stride    = r_stride;
        n_prod      = r_prod;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_pix   = r_out_pix;
        n_out_oor   = r_out_oor;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state   = S_CLIP;
                    n_is_read = (i_cmd == CMD_READ);
                    n_x       = i_pos_x;
                    n_y       = i_pos_y;
                    n_color   = {i_red_in, i_green_in, i_blue_in};
                    case (i_cmd)
                        CMD_READ, CMD_WRITE: begin
                            n_w = 9'd1;
                            n_h = 9'd1;
                        end
                        CMD_HLINE: begin
                            n_w = i_span_len;
                            n_h = thick_eff;
                        end
                        CMD_VLINE: begin
                            n_w = thick_eff;
                            n_h = i_span_len;
                        end
                        CMD_BOX: begin
                            n_w = i_span_len;
                            n_h = i_box_rows;
                        end
                        CMD_CLEAR: begin
                            n_x = '0;
                            n_y = '0;
                            n_w = cw;
                            n_h = ch;
                        end
                        default: begin
                            n_w = '0;
                            n_h = '0;
                        end
                    endcase
                end
            end
            S_CLIP: begin
                n_x0    = x0_c;
                n_x1    = x1_c;
                n_y0    = y0_c;
                n_y1    = y1_c;
                n_state = S_BASE;
            end
            S_BASE: begin
                n_prod   = {{SIZE_W{1'b0}}, r_y0} * {{SIZE_W{1'b0}}, cw};
                n_stride = stride_c[SIZE_W-1:0];
                n_col    = r_x0;
                n_row    = r_y0;
                n_oor    = empty;
                if (!empty) begin
                    n_state = S_START;
                end else if (r_is_read) begin
                    n_state = S_RDWAIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_START: begin
                n_addr  = add_sum;
                n_state = S_FILL;
            end
            S_FILL: begin
                n_addr = add_sum;
                if (row_end) begin
                    n_col = r_x0;
                    n_row = r_row + 9'd1;
                end else begin
                    n_col = r_col + 9'd1;
                end
                if (r_is_read) begin
                    n_state = S_RDWAIT;
                end else if (row_end && last_row) begin
                    n_state = S_IDLE;
                end
            end
            S_RDWAIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pix   = r_oor ? '0 : ram_rdata;
                    n_out_oor   = r_oor;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_canvas_w  <= RST_CANVAS_W;
            r_canvas_h  <= RST_CANVAS_H;
            r_thick     <= RST_THICK;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_canvas_w  <= n_canvas_w;
            r_canvas_h  <= n_canvas_h;
            r_thick     <= n_thick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_read <= n_is_read;
        r_oor     <= n_oor;
        r_x       <= n_x;
        r_y       <= n_y;
        r_w       <= n_w;
        r_h       <= n_h;
        r_color   <= n_color;
        r_x0      <= n_x0;
        r_x1      <= n_x1;
        r_y0      <= n_y0;
        r_y1      <= n_y1;
        r_col     <= n_col;
        r_row     <= n_row;
        r_stride  <= n_stride;
        r_prod    <= n_prod;
        r_addr    <= n_addr;
        r_out_pix <= n_out_pix;
        r_out_oor <= n_out_oor;
    end

    cfb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (r_addr),
        .i_wdata (r_color),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_red_out      = r_out_pix[PIX_W-1 -: CH_W];
    assign o_green_out    = r_out_pix[CH_W +: CH_W];
    assign o_blue_out     = r_out_pix[CH_W-1:0];
    assign o_out_of_range = r_out_oor;

endmodule

@@ design/cfb_checker.sv @@
module cfb_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [cfb_pkg::CH_W-1:0]           o_red_out,
    input logic [cfb_pkg::CH_W-1:0]           o_green_out,
    input logic [cfb_pkg::CH_W-1:0]           o_blue_out,
    input logic                               o_out_of_range
);

    // after an accepted command the input stalls in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_red_out) &&
            $stable(o_green_out) && $stable(o_blue_out) && $stable(o_out_of_range)))
        else $error("stalled output beat changed");

    a_oor_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |->
            (o_red_out == '0 && o_green_out == '0 && o_blue_out == '0))
        else $error("out-of-range read returned nonzero color");

    // a new result only comes out of a busy read
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a command in flight");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("reset did not clear handshake state");

endmodule

bind clipped_framebuffer_fill cfb_checker u_cfb_checker (.*);
